// ===== hdl/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

  // Fixed field widths of the request, response and configuration beats, and of the access stamps.
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int STAMP_W = 32;

  // Reset value of the capacity register.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Data returned on a get that misses and on any put.
  localparam logic [DATA_W-1:0] MISS_DATA = '1;
  localparam logic [DATA_W-1:0] PUT_DATA  = '0;

  typedef enum logic [0:0] {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Findings of one pass over the table.
  typedef struct packed {
    logic hit;
    logic victim;
    logic free;
  } scan_flags_t;

endpackage

// ===== hdl/lfu_req_if.sv =====
`timescale 1ns / 1ps

interface lfu_req_if;
  logic                             valid;
  logic                             ready;
  lfu_pkg::op_t                     op;
  logic signed [lfu_pkg::KEY_W-1:0]  key;
  logic signed [lfu_pkg::DATA_W-1:0] data_in;

  modport source (output valid, op, key, data_in, input ready);
  modport sink (input valid, op, key, data_in, output ready);
endinterface

// ===== hdl/lfu_rsp_if.sv =====
`timescale 1ns / 1ps

interface lfu_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [lfu_pkg::DATA_W-1:0] data_out;
  logic                              evicted;

  modport source (output valid, hit, data_out, evicted, input ready);
  modport sink (input valid, hit, data_out, evicted, output ready);
endinterface

// ===== hdl/lfu_cfg_if.sv =====
`timescale 1ns / 1ps

interface lfu_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lfu_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/lfu_scan_unit.sv =====
`timescale 1ns / 1ps

// Compares one table entry per beat against the lookup key and keeps the
// running hit, eviction candidate and first free slot of the pass.
module lfu_scan_unit #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 16
) (
  input  logic                          clk,
  input  logic                          clr,
  input  logic                          beat,
  input  logic                          ent_valid,
  input  logic [IDX_W-1:0]              ent_idx,
  input  logic [lfu_pkg::KEY_W-1:0]     ent_key,
  input  logic [CNT_W-1:0]              ent_count,
  input  logic [lfu_pkg::STAMP_W-1:0]   ent_stamp,
  input  logic [lfu_pkg::KEY_W-1:0]     look_key,
  input  logic [lfu_pkg::STAMP_W-1:0]   now_clock,
  output lfu_pkg::scan_flags_t          flags,
  output logic [IDX_W-1:0]              hit_idx,
  output logic [CNT_W-1:0]              hit_count,
  output logic [IDX_W-1:0]              victim_idx,
  output logic [IDX_W-1:0]              free_idx
);

  logic [CNT_W-1:0]            victim_count;
  logic [lfu_pkg::STAMP_W-1:0] victim_age;
  logic [lfu_pkg::STAMP_W-1:0] age;
  logic                        better;

  // Age modulo 2^32 keeps the recency order correct across clock wrap.
  assign age    = now_clock - ent_stamp;
  assign better = !flags.victim || (ent_count < victim_count) ||
                  ((ent_count == victim_count) && (age > victim_age));

  always_ff @(posedge clk) begin
    if (clr) begin
      flags <= '0;
    end else if (beat) begin
      if (ent_valid) begin
        if (!flags.hit && (ent_key == look_key)) begin
          flags.hit <= 1'b1;
          hit_idx   <= ent_idx;
          hit_count <= ent_count;
        end
        if (better) begin
          flags.victim <= 1'b1;
          victim_idx   <= ent_idx;
          victim_count <= ent_count;
          victim_age   <= age;
        end
      end else if (!flags.free) begin
        flags.free <= 1'b1;
        free_idx   <= ent_idx;
      end
    end
  end

endmodule

// ===== hdl/lfu_cache_table_core.sv =====
`timescale 1ns / 1ps

// Sequence: idle latches a request, scan sweeps the entry memories one entry per
//   cycle with one compare unit, then drain, update and finish; finish waits for
//   a free response register. A new request is taken only back in idle.
// Reset: rst is synchronous, clears every valid bit, the access clock, the
//   occupancy count and the handshakes, and sets the capacity register to 16.
module lfu_cache_table_core #(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  lfu_req_if.sink    req,
  lfu_rsp_if.source  rsp,
  lfu_cfg_if.sink    cfg
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = (OCC_W > lfu_pkg::CFG_W) ? OCC_W : lfu_pkg::CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_ENTRIES);
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [lfu_pkg::STAMP_W-1:0] STAMP_ONE = lfu_pkg::STAMP_W'(1);

  // Control state.
  lfu_pkg::state_t               state;
  lfu_pkg::state_t               state_next;
  logic [lfu_pkg::CFG_W-1:0]     entries_in_use;
  logic [MAX_ENTRIES-1:0]        entry_valid;
  logic [lfu_pkg::STAMP_W-1:0]   access_clock;
  logic [OCC_W-1:0]              occupied;
  logic [IDX_W-1:0]              scan_addr;
  logic                          rd_vld;
  logic                          rsp_vld;

  // Latched request.
  lfu_pkg::op_t                  cur_op;
  logic [lfu_pkg::KEY_W-1:0]     cur_key;
  logic [lfu_pkg::DATA_W-1:0]    cur_data;

  // Entry memories; an entry is only looked at while its valid bit is set.
  logic [lfu_pkg::KEY_W-1:0]     key_mem   [MAX_ENTRIES];
  logic [lfu_pkg::DATA_W-1:0]    value_mem [MAX_ENTRIES];
  logic [COUNT_WIDTH-1:0]        count_mem [MAX_ENTRIES];
  logic [lfu_pkg::STAMP_W-1:0]   stamp_mem [MAX_ENTRIES];

  logic [lfu_pkg::KEY_W-1:0]     rd_key;
  logic [COUNT_WIDTH-1:0]        rd_count;
  logic [lfu_pkg::STAMP_W-1:0]   rd_stamp;
  logic [IDX_W-1:0]              rd_idx;
  logic [lfu_pkg::DATA_W-1:0]    value_rd;

  // Scan results.
  lfu_pkg::scan_flags_t          flags;
  logic [IDX_W-1:0]              hit_idx;
  logic [COUNT_WIDTH-1:0]        hit_count;
  logic [IDX_W-1:0]              victim_idx;
  logic [IDX_W-1:0]              free_idx;

  // Decision made in the update step.
  logic                          res_hit;
  logic                          res_evicted;
  logic [lfu_pkg::DATA_W-1:0]    rsp_data;
  logic                          rsp_hit;
  logic                          rsp_evicted;

  // Combinational control.
  logic                          req_accept;
  logic                          rsp_free;
  logic                          scan_clr;
  logic                          issue;
  logic                          do_update;
  logic                          do_finish;
  logic [CAP_W-1:0]              cap_raw;
  logic [CAP_W-1:0]              capacity;
  logic                          table_full;
  logic                          evict;
  logic                          slot_ok;
  logic [IDX_W-1:0]              slot;
  logic [COUNT_WIDTH-1:0]        bumped_count;
  logic                          mem_we;
  logic                          val_we;
  logic [IDX_W-1:0]              wr_idx;
  logic [COUNT_WIDTH-1:0]        wr_count;
  logic                          clock_step;

  assign cfg.ready  = 1'b1;
  assign req_accept = req.valid && req.ready;
  assign rsp_free   = !rsp_vld || rsp.ready;

  // Capacity register: 0 behaves as 1, anything above the table size as
  // the table size.
  assign cap_raw    = CAP_W'(entries_in_use);
  assign capacity   = (cap_raw == '0) ? CAP_W'(1) :
                      (cap_raw > CAP_MAX) ? CAP_MAX : cap_raw;
  assign table_full = CAP_W'(occupied) >= capacity;

  // A put miss evicts only when the table is at capacity. The new entry
  // takes the lowest free slot, which may be the slot just vacated.
  assign evict = table_full && flags.victim;
  always_comb begin
    if (evict) begin
      slot_ok = 1'b1;
      slot    = (flags.free && (free_idx < victim_idx)) ? free_idx : victim_idx;
    end else begin
      slot_ok = flags.free;
      slot    = free_idx;
    end
  end

  // Use counts stop at their maximum.
  assign bumped_count = (hit_count == '1) ? hit_count : hit_count + COUNT_ONE;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (req_accept) begin
          state_next = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_addr == LAST_IDX) begin
          state_next = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN: begin
        state_next = lfu_pkg::ST_UPDATE;
      end
      lfu_pkg::ST_UPDATE: begin
        state_next = lfu_pkg::ST_FINISH;
      end
      lfu_pkg::ST_FINISH: begin
        if (rsp_free) begin
          state_next = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    req.ready = 1'b0;
    issue     = 1'b0;
    do_update = 1'b0;
    do_finish = 1'b0;
    unique case (state)
      lfu_pkg::ST_IDLE:   req.ready = 1'b1;
      lfu_pkg::ST_SCAN:   issue     = 1'b1;
      lfu_pkg::ST_DRAIN:  ;
      lfu_pkg::ST_UPDATE: do_update = 1'b1;
      lfu_pkg::ST_FINISH: do_finish = rsp_free;
      default:            ;
    endcase
  end

  assign scan_clr = rst || req_accept;

  // Writes of the update step. A hit refreshes the hit entry, a put miss
  // installs a new entry with a count of one; a get miss writes nothing.
  always_comb begin
    mem_we     = 1'b0;
    val_we     = 1'b0;
    wr_idx     = hit_idx;
    wr_count   = bumped_count;
    clock_step = 1'b0;
    if (do_update) begin
      if (flags.hit) begin
        mem_we     = 1'b1;
        val_we     = (cur_op == lfu_pkg::OP_PUT);
        clock_step = 1'b1;
      end else if ((cur_op == lfu_pkg::OP_PUT) && slot_ok) begin
        mem_we     = 1'b1;
        val_we     = 1'b1;
        wr_idx     = slot;
        wr_count   = COUNT_ONE;
        clock_step = 1'b1;
      end
    end
  end

  // Entry memories: one read port swept by the scan, one write port.
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[scan_addr];
    rd_count <= count_mem[scan_addr];
    rd_stamp <= stamp_mem[scan_addr];
    rd_idx   <= scan_addr;
    if (mem_we) begin
      key_mem[wr_idx]   <= cur_key;
      count_mem[wr_idx] <= wr_count;
      stamp_mem[wr_idx] <= access_clock;
    end
  end

  always_ff @(posedge clk) begin
    value_rd <= value_mem[hit_idx];
    if (val_we) begin
      value_mem[wr_idx] <= cur_data;
    end
  end

  lfu_scan_unit #(
    .IDX_W (IDX_W),
    .CNT_W (COUNT_WIDTH)
  ) u_scan (
    .clk        (clk),
    .clr        (scan_clr),
    .beat       (rd_vld),
    .ent_valid  (entry_valid[rd_idx]),
    .ent_idx    (rd_idx),
    .ent_key    (rd_key),
    .ent_count  (rd_count),
    .ent_stamp  (rd_stamp),
    .look_key   (cur_key),
    .now_clock  (access_clock),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .hit_count  (hit_count),
    .victim_idx (victim_idx),
    .free_idx   (free_idx)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lfu_pkg::ST_IDLE;
      entries_in_use <= lfu_pkg::CFG_RESET;
      entry_valid    <= '0;
      access_clock   <= '0;
      occupied       <= '0;
      scan_addr      <= '0;
      rd_vld         <= 1'b0;
      rsp_vld        <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg.valid) begin
        entries_in_use <= cfg.data;
      end
      if (req_accept) begin
        scan_addr <= '0;
      end else if (issue && (scan_addr != LAST_IDX)) begin
        scan_addr <= scan_addr + IDX_W'(1);
      end
      if (clock_step) begin
        access_clock <= access_clock + STAMP_ONE;
      end
      if (do_update && !flags.hit && (cur_op == lfu_pkg::OP_PUT)) begin
        // When the new entry reuses the vacated slot its bit simply stays set.
        if (evict && (slot != victim_idx)) begin
          entry_valid[victim_idx] <= 1'b0;
        end
        if (slot_ok) begin
          entry_valid[slot] <= 1'b1;
        end
        if (slot_ok && !evict) begin
          occupied <= occupied + OCC_W'(1);
        end else if (!slot_ok && evict) begin
          occupied <= occupied - OCC_W'(1);
        end
      end
      if (do_finish) begin
        rsp_vld <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      cur_op   <= req.op;
      cur_key  <= req.key;
      cur_data <= req.data_in;
    end
    if (do_update) begin
      res_hit     <= flags.hit;
      res_evicted <= (cur_op == lfu_pkg::OP_PUT) && !flags.hit && evict;
    end
    if (do_finish) begin
      rsp_hit     <= res_hit;
      rsp_evicted <= res_evicted;
      if (cur_op == lfu_pkg::OP_PUT) begin
        rsp_data <= lfu_pkg::PUT_DATA;
      end else if (res_hit) begin
        rsp_data <= value_rd;
      end else begin
        rsp_data <= lfu_pkg::MISS_DATA;
      end
    end
  end

  assign rsp.valid    = rsp_vld;
  assign rsp.hit      = rsp_hit;
  assign rsp.data_out = rsp_data;
  assign rsp.evicted  = rsp_evicted;

  // The occupancy count always agrees with the valid bits.
  assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == occupied)
    else $error("occupancy count differs from number of valid entries");

  // An eviction only ever answers a put that missed.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.evicted) |-> !rsp.hit)
    else $error("eviction reported together with a hit");

  // The access clock only moves in the update step.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(access_clock)) |-> ($past(state) == lfu_pkg::ST_UPDATE))
    else $error("access clock changed outside the update step");

  // No request is taken while a scan is still in flight.
  assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> !req.ready)
    else $error("request ready during a table scan");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the LFU cache table. Every request beat that the
// core accepts is run through a predictor kept in this module, and the
// predicted response is queued. Each response beat is checked, field by
// field, against the oldest queued prediction.
module testbench;

  // The core is built at its default size, so the predictor matches it.
  localparam int SLOTS = 16;
  localparam int COUNT_W = 16;
  // The quiet time left after the last response, sized from the table depth.
  localparam int SETTLE_CYCLES = SLOTS + 8;
  // Watchdog on the whole run in ns, far beyond what a correct run takes.
  localparam int RUN_LIMIT_NS = 5_000_000;
  // Mismatches keep counting past this, but stop printing.
  localparam int MAX_PRINTED = 60;

  typedef struct packed {
    logic                       hit;
    logic [lfu_pkg::DATA_W-1:0] data_out;
    logic                       evicted;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst;

  lfu_req_if req_bus ();
  lfu_rsp_if rsp_bus ();
  lfu_cfg_if cfg_bus ();

  lfu_cache_table_core #(
    .MAX_ENTRIES(SLOTS),
    .COUNT_WIDTH(COUNT_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The predictor's copy of the table. Keys, values, counts and stamps are
  // only ever read for slots whose valid bit is set.
  bit                          tag_valid [SLOTS];
  logic [lfu_pkg::KEY_W-1:0]   tag_key [SLOTS];
  logic [lfu_pkg::DATA_W-1:0]  tag_value [SLOTS];
  logic [COUNT_W-1:0]          use_count [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] touch_stamp [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] access_tick;
  int                          fill_level;
  logic [lfu_pkg::CFG_W-1:0]   capacity_reg;

  // Responses still owed by the core, oldest first.
  lookup_result_t results_pending[$];

  // Percent chance of a gap before a request, and of ready low per cycle.
  int gap_pct = 24;
  int stall_pct = 24;

  int fail_count = 0;
  int accesses_sent = 0;
  int results_checked = 0;
  int hits_predicted = 0;
  int evictions_predicted = 0;
  int cfg_writes = 0;

  logic [lfu_pkg::KEY_W-1:0] key_pool [40];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < MAX_PRINTED)
      $display("MISMATCH at %0t, response %0d, %s: got %h, expected %h",
               $realtime, results_checked, what, got, want);
    fail_count++;
  endtask

  // A hit bumps the use count unless it is already saturated. Every touch
  // takes the current access tick as its recency stamp, then advances it.
  function automatic void touch_slot(int idx, bit bump);
    if (bump && use_count[idx] != '1)
      use_count[idx] = use_count[idx] + 1'b1;
    touch_stamp[idx] = access_tick;
    access_tick = access_tick + 1'b1;
  endfunction

  function automatic lookup_result_t predict_access(lfu_pkg::op_t op,
                                                    logic [lfu_pkg::KEY_W-1:0] key,
                                                    logic [lfu_pkg::DATA_W-1:0] data);
    int found = -1;
    int victim = -1;
    int slot = -1;
    int cap;
    logic [COUNT_W-1:0] low_count = '0;
    logic [lfu_pkg::STAMP_W-1:0] oldest_age = '0;
    logic [lfu_pkg::STAMP_W-1:0] age;
    lookup_result_t r;
    r.hit = 1'b0;
    r.data_out = lfu_pkg::PUT_DATA;
    r.evicted = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && tag_valid[i] && tag_key[i] == key)
        found = i;
    if (op == lfu_pkg::OP_GET) begin
      if (found >= 0) begin
        r.hit = 1'b1;
        touch_slot(found, 1'b1);
        r.data_out = tag_value[found];
      end else begin
        // A get miss leaves everything alone, the access tick included.
        r.data_out = lfu_pkg::MISS_DATA;
      end
    end else if (found >= 0) begin
      r.hit = 1'b1;
      tag_value[found] = data;
      touch_slot(found, 1'b1);
    end else begin
      // A zero capacity behaves as one; anything above the table size is clamped.
      if (capacity_reg == 0)
        cap = 1;
      else if (capacity_reg > SLOTS)
        cap = SLOTS;
      else
        cap = int'(capacity_reg);
      // The table may hold more than the capacity after it was lowered. A miss
      // then still evicts only one entry, so occupancy stays where it is.
      if (fill_level >= cap) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tag_valid[i]) begin
            age = access_tick - touch_stamp[i];
            // Strict compares keep the lowest index when everything ties.
            if (victim < 0 || use_count[i] < low_count ||
                (use_count[i] == low_count && age > oldest_age)) begin
              victim = i;
              low_count = use_count[i];
              oldest_age = age;
            end
          end
        end
        if (victim >= 0) begin
          tag_valid[victim] = 1'b0;
          fill_level--;
          r.evicted = 1'b1;
        end
      end
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && !tag_valid[i])
          slot = i;
      if (slot >= 0) begin
        tag_valid[slot] = 1'b1;
        tag_key[slot] = key;
        tag_value[slot] = data;
        use_count[slot] = 1;
        touch_slot(slot, 1'b0);
        fill_level++;
      end
    end
    if (r.hit)
      hits_predicted++;
    if (r.evicted)
      evictions_predicted++;
    return r;
  endfunction

  // Sends one request beat. An optional gap comes first with valid low.
  // Without a gap, valid simply stays high from the previous beat, so valid
  // never gets two assignments in the same edge.
  task automatic send_access(lfu_pkg::op_t op, logic [lfu_pkg::KEY_W-1:0] key,
                             logic [lfu_pkg::DATA_W-1:0] data);
    int gap = 0;
    while ($urandom_range(0, 99) < gap_pct)
      gap++;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.key <= key;
    req_bus.data_in <= data;
    @(posedge clk);
    while (!req_bus.ready)
      @(posedge clk);
    results_pending.push_back(predict_access(op, key, data));
    accesses_sent++;
  endtask

  // Drops valid and holds off until every owed response has been checked.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (results_pending.size() != 0)
      @(posedge clk);
  endtask

  // Capacity writes happen only with the core idle: every owed response is
  // checked first, and a short settle follows.
  task automatic write_capacity(logic [lfu_pkg::CFG_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready)
      @(posedge clk);
    cfg_bus.valid <= 1'b0;
    capacity_reg = value;
    cfg_writes++;
  endtask

  // Response side: ready is randomized each cycle, and every beat that
  // completes is compared with the oldest prediction.
  always @(posedge clk) begin
    lookup_result_t want;
    rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (results_pending.size() == 0) begin
        report_mismatch("beat with no request outstanding", rsp_bus.data_out, '0);
      end else begin
        want = results_pending.pop_front();
        if (rsp_bus.hit !== want.hit)
          report_mismatch("hit", rsp_bus.hit, want.hit);
        if (rsp_bus.data_out !== want.data_out)
          report_mismatch("data_out", rsp_bus.data_out, want.data_out);
        if (rsp_bus.evicted !== want.evicted)
          report_mismatch("evicted", rsp_bus.evicted, want.evicted);
      end
      results_checked++;
    end
  end

  // Extreme keys and values at the reset capacity: installs, hits, a miss,
  // and a put that overwrites an existing value.
  task automatic test_basic_access();
    send_access(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_access(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Gets carry random data, which the core must ignore.
    send_access(lfu_pkg::OP_GET, 32'h8000_0000, $urandom);
    send_access(lfu_pkg::OP_GET, 32'h7FFF_FFFF, $urandom);
    send_access(lfu_pkg::OP_GET, 32'h0000_0000, $urandom);
    send_access(lfu_pkg::OP_GET, 32'hFFFF_FFFF, $urandom);
    send_access(lfu_pkg::OP_GET, 32'h0000_0005, $urandom);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
    send_access(lfu_pkg::OP_GET, 32'h0000_0000, $urandom);
  endtask

  // Capacity out of range both ways. Zero behaves as one, so with four
  // entries already present each new key evicts once and occupancy holds.
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0010, 32'h1111_1111);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0011, 32'h2222_2222);
    send_access(lfu_pkg::OP_GET, 32'h0000_0010, $urandom);
    // All ones is clamped to the table size, so free slots fill first.
    write_capacity(5'd31);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0020, 32'h3333_3333);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0021, 32'h4444_4444);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0022, 32'h5555_5555);
    send_access(lfu_pkg::OP_GET, 32'h8000_0000, $urandom);
  endtask

  // Victim choice by count, with recency deciding among equal counts.
  task automatic test_victim_order();
    write_capacity(5'd2);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0030, 32'hAAAA_0001);
    send_access(lfu_pkg::OP_GET, 32'h0000_0030, $urandom);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0031, 32'hAAAA_0002);
    send_access(lfu_pkg::OP_PUT, 32'h0000_0032, 32'hAAAA_0003);
  endtask

  // One phase of random traffic at a given capacity. Most keys come from a
  // pool a little larger than the capacity, with a hot subset, so there are
  // plenty of hits, count differences and evictions; a few keys are fresh.
  task automatic run_mix_phase(int items, logic [lfu_pkg::CFG_W-1:0] cap_value,
                               bit pause_midway);
    int pool_n;
    int hot_n;
    int pick;
    logic [lfu_pkg::KEY_W-1:0] key;
    write_capacity(cap_value);
    pool_n = ((cap_value == 0) ? 1 : ((cap_value > SLOTS) ? SLOTS : int'(cap_value)))
             + $urandom_range(1, 8);
    hot_n = pool_n / 4 + 1;
    for (int i = 0; i < pool_n; i++)
      key_pool[i] = $urandom;
    for (int n = 0; n < items; n++) begin
      // Halfway through, the sender stops until the core has caught up.
      if (pause_midway && n == items / 2)
        wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 8)
        key = $urandom;
      else if (pick < 50)
        key = key_pool[$urandom_range(0, hot_n - 1)];
      else
        key = key_pool[$urandom_range(0, pool_n - 1)];
      send_access(lfu_pkg::op_t'($urandom_range(0, 1)), key, $urandom);
    end
  endtask

  // Random traffic across a range of capacities, the extremes among them.
  task automatic test_random_mix();
    run_mix_phase(130, 5'd1, 1'b0);
    run_mix_phase(130, 5'd31, 1'b1);
    run_mix_phase(130, 5'd0, 1'b0);
    run_mix_phase(130, 5'd2, 1'b0);
    run_mix_phase(130, 5'd17, 1'b0);
    run_mix_phase(130, 5'd8, 1'b1);
    run_mix_phase(130, 5'($urandom_range(0, 31)), 1'b0);
    run_mix_phase(130, 5'($urandom_range(0, 31)), 1'b0);
    run_mix_phase(130, 5'd16, 1'b0);
    run_mix_phase(130, 5'd3, 1'b0);
  endtask

  // A long stretch with neither side idling, back to back through the core.
  task automatic test_back_to_back();
    gap_pct = 0;
    stall_pct = 0;
    run_mix_phase(320, 5'd4, 1'b0);
    wait_drained();
    gap_pct = 24;
    stall_pct = 24;
  endtask

  initial begin
    #RUN_LIMIT_NS;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.op <= lfu_pkg::OP_GET;
    req_bus.key <= '0;
    req_bus.data_in <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data <= '0;
    // The predictor starts from the same state the core resets to.
    for (int i = 0; i < SLOTS; i++)
      tag_valid[i] = 1'b0;
    access_tick = '0;
    fill_level = 0;
    capacity_reg = lfu_pkg::CFG_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_basic_access();
    test_capacity_limits();
    test_victim_order();
    test_random_mix();
    test_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_pending.size() != 0)
      report_mismatch("responses never returned", results_pending.size(), 0);
    $display("Ran %0d accesses through the cache: %0d hits, %0d evictions.",
             accesses_sent, hits_predicted, evictions_predicted);
    $display("Capacity was rewritten %0d times; %0d responses were checked.",
             cfg_writes, results_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lfu_pkg.sv
hdl/lfu_req_if.sv
hdl/lfu_rsp_if.sv
hdl/lfu_cfg_if.sv
hdl/lfu_scan_unit.sv
hdl/lfu_cache_table_core.sv
sim/testbench.sv
